// ===== rtl/elru_pkg.sv =====
// Shared types, level codes and cost tables for the exclusive LRU lookup.
`default_nettype none

package elru_pkg;

  localparam int TAG_W   = 20;
  localparam int AGE_W   = 32;
  localparam int LEVEL_W = 3;
  localparam int SLOT_W  = 3;
  localparam int COST_W  = 17;
  localparam int CYC_W   = 14;
  localparam int SUM_W   = 32;

  // Hit level codes.
  localparam logic [LEVEL_W-1:0] LVL_L1   = 3'd0;
  localparam logic [LEVEL_W-1:0] LVL_L2   = 3'd1;
  localparam logic [LEVEL_W-1:0] LVL_L3   = 3'd2;
  localparam logic [LEVEL_W-1:0] LVL_RAM  = 3'd3;
  localparam logic [LEVEL_W-1:0] LVL_DISK = 3'd4;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  // One stored entry of any level.
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } entry_t;

  // Control of the shared compare unit.
  typedef struct packed {
    logic clear;
    logic victim;
    logic en;
  } scan_ctl_t;

  function automatic logic [COST_W-1:0] cost_of(input logic [LEVEL_W-1:0] lvl);
    logic [COST_W-1:0] c;
    case (lvl)
      LVL_L1:  c = 17'd10;
      LVL_L2:  c = 17'd110;
      LVL_L3:  c = 17'd1110;
      LVL_RAM: c = 17'd11110;
      default: c = 17'd111110;
    endcase
    return c;
  endfunction

  function automatic logic [CYC_W-1:0] cycles_of(input logic [LEVEL_W-1:0] lvl);
    logic [CYC_W-1:0] c;
    case (lvl)
      LVL_L1:  c = 14'd1;
      LVL_L2:  c = 14'd10;
      LVL_L3:  c = 14'd100;
      LVL_RAM: c = 14'd1000;
      default: c = 14'd10000;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/elru_if.sv =====
// Request and response channel interfaces of the exclusive LRU lookup.
`default_nettype none

interface elru_req_if;
  logic        valid;
  logic        ready;
  logic [19:0] block_address;

  modport source (output valid, output block_address, input ready);
  modport sink (input valid, input block_address, output ready);
endinterface

interface elru_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  hit_level;
  logic [2:0]  l1_slot;
  logic        resident;
  logic [16:0] access_cost;
  logic [13:0] access_cycles;
  logic [31:0] total_cost;
  logic [31:0] total_cycles;

  modport source (output valid, output hit_level, output l1_slot, output resident,
                  output access_cost, output access_cycles, output total_cost,
                  output total_cycles, input ready);
  modport sink (input valid, input hit_level, input l1_slot, input resident,
                input access_cost, input access_cycles, input total_cost,
                input total_cycles, output ready);
endinterface

`default_nettype wire

// ===== rtl/elru_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module elru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/elru_scan.sv =====
// Shared compare unit: tracks the victim or the youngest entry over one level scan.
`default_nettype none

module elru_scan #(
  parameter int IW = 7
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire elru_pkg::scan_ctl_t ctl,
  input  wire logic [IW-1:0]      idx,
  input  wire elru_pkg::entry_t   entry,
  output logic      [IW-1:0]      best_idx,
  output elru_pkg::entry_t        best,
  output logic                    inv_hit,
  output logic                    have
);

  logic cmp;

  // One age comparator serves both searches.
  assign cmp = ctl.victim ? (entry.age > best.age) : (entry.age < best.age);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      inv_hit <= 1'b0;
      have    <= 1'b0;
    end else if (ctl.en) begin
      if (ctl.victim) begin
        // First invalid entry wins outright, else the first of greatest age.
        if (!inv_hit) begin
          if (!entry.valid) begin
            inv_hit  <= 1'b1;
            best_idx <= idx;
            best     <= entry;
          end else if (!have || cmp) begin
            best_idx <= idx;
            best     <= entry;
          end
          have <= 1'b1;
        end
      end else if (entry.valid && (!have || cmp)) begin
        // First valid entry of least age.
        best_idx <= idx;
        best     <= entry;
        have     <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/exclusive_four_level_lru_lookup.sv =====
// Top level: four exclusive tag levels in one RAM, walked by a sequencer.
//
// Usage: each request beat on req carries one block address; each response
// beat on rsp carries the hit level, the L1 slot holding the block, the cost
// and cycle charge of the access and the saturating running totals.
// All levels live in one RAM of N = FIRST+SECOND+THIRD+MAIN entries.
// After reset a clearing pass writes every entry invalid, during which
// req.ready stays low. One access at a time: an aging pass over all N
// entries (one RAM read and write per cycle) also finds the hit, then the
// sequencer runs level scans through the one compare unit, and each swap
// writes both of its entries. The aging pass and the scans share the single
// RAM read port. req.ready is high only while the sequencer is idle. A
// finished response waits in the output register; a stalled receiver holds
// the next result back in its last step until the current beat is taken.
`default_nettype none

module exclusive_four_level_lru_lookup #(
  parameter int FIRST_ENTRIES  = 8,
  parameter int SECOND_ENTRIES = 16,
  parameter int THIRD_ENTRIES  = 32,
  parameter int MAIN_ENTRIES   = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  elru_req_if.sink  req,
  elru_rsp_if.source rsp
);

  localparam int N  = FIRST_ENTRIES + SECOND_ENTRIES + THIRD_ENTRIES + MAIN_ENTRIES;
  localparam int IW = $clog2(N);
  localparam logic [IW-1:0] B1   = IW'(FIRST_ENTRIES);
  localparam logic [IW-1:0] B2   = IW'(FIRST_ENTRIES + SECOND_ENTRIES);
  localparam logic [IW-1:0] B3   = IW'(FIRST_ENTRIES + SECOND_ENTRIES + THIRD_ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(N - 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_AGE   = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_MISS  = 4'd4;
  localparam logic [3:0] S_DOWN  = 4'd5;
  localparam logic [3:0] S_DOWN2 = 4'd6;
  localparam logic [3:0] S_HOLE  = 4'd7;
  localparam logic [3:0] S_FILL  = 4'd8;
  localparam logic [3:0] S_FILL2 = 4'd9;
  localparam logic [3:0] S_SLOT  = 4'd10;
  localparam logic [3:0] S_L1HIT = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  function automatic logic [IW-1:0] lvl_base(input logic [1:0] k);
    logic [IW-1:0] b;
    case (k)
      2'd0:    b = '0;
      2'd1:    b = B1;
      2'd2:    b = B2;
      default: b = B3;
    endcase
    return b;
  endfunction

  function automatic logic [IW-1:0] lvl_last(input logic [1:0] k);
    logic [IW-1:0] b;
    case (k)
      2'd0:    b = B1 - 1'b1;
      2'd1:    b = B2 - 1'b1;
      2'd2:    b = B3 - 1'b1;
      default: b = LAST;
    endcase
    return b;
  endfunction

  function automatic logic [1:0] lvl_of(input logic [IW-1:0] i);
    logic [1:0] k;
    if (i >= B3) k = 2'd3;
    else if (i >= B2) k = 2'd2;
    else if (i >= B1) k = 2'd1;
    else k = 2'd0;
    return k;
  endfunction

  logic [3:0]                     state;
  logic [3:0]                     ret;
  logic [IW-1:0]                  cnt;
  logic [IW-1:0]                  slast;
  logic                           iss;
  logic                           pv;
  logic [IW-1:0]                  paddr;
  logic                           scan_clr;
  logic                           scan_vic;
  logic [elru_pkg::TAG_W-1:0]     addr;
  logic                           hit_found;
  logic [IW-1:0]                  hit_idx;
  logic [elru_pkg::LEVEL_W-1:0]   hit_level;
  logic [1:0]                     k;
  logic [1:0]                     top_lvl;
  logic [2:0]                     j;
  logic [IW-1:0]                  idx;
  logic [IW-1:0]                  hole_idx;
  elru_pkg::entry_t               hold;
  logic [elru_pkg::SLOT_W-1:0]    slot;

  logic                           rsp_valid;
  logic [elru_pkg::LEVEL_W-1:0]   out_level;
  logic [elru_pkg::SLOT_W-1:0]    out_slot;
  logic [elru_pkg::COST_W-1:0]    out_cost;
  logic [elru_pkg::CYC_W-1:0]     out_cyc;
  logic [elru_pkg::SUM_W-1:0]     total_cost;
  logic [elru_pkg::SUM_W-1:0]     total_cycles;

  logic                           we;
  logic [IW-1:0]                  waddr;
  elru_pkg::entry_t               wdata;
  elru_pkg::entry_t               rdata;

  elru_pkg::scan_ctl_t            ctl;
  logic [IW-1:0]                  best_idx;
  elru_pkg::entry_t               best;
  logic                           inv_hit;
  logic                           have;

  logic                           hit_now;
  logic                           found_any;
  logic [IW-1:0]                  fidx;
  logic [1:0]                     flvl;
  logic                           age_end;

  logic                           go_scan;
  logic [1:0]                     go_lvl;
  logic                           go_vic;
  logic [3:0]                     go_ret;
  logic [2:0]                     au_j;
  logic [1:0]                     au_lvl;
  logic                           au_vic;
  logic [3:0]                     au_ret;

  logic [elru_pkg::SUM_W:0]       cost_sum;
  logic [elru_pkg::SUM_W:0]       cyc_sum;

  elru_ram #(
    .WIDTH ($bits(elru_pkg::entry_t)),
    .DEPTH (N)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt),
    .rdata (rdata)
  );

  assign ctl.clear  = scan_clr;
  assign ctl.victim = scan_vic;
  assign ctl.en     = pv && (state == S_SCAN);

  elru_scan #(.IW(IW)) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .idx      (paddr),
    .entry    (rdata),
    .best_idx (best_idx),
    .best     (best),
    .inv_hit  (inv_hit),
    .have     (have)
  );

  // Hit detection during the aging pass.
  assign hit_now   = pv && (state == S_AGE) && rdata.valid && (rdata.tag == addr);
  assign found_any = hit_found || hit_now;
  assign fidx      = hit_found ? hit_idx : paddr;
  assign flvl      = lvl_of(fidx);
  assign age_end   = pv && (state == S_AGE) && (paddr == LAST);

  // Next step of the refill walk: a hole check of level j-1, or the final slot scan.
  always_comb begin
    au_j = (state == S_DOWN2) ? 3'd2 : (j + 3'd1);
    if (au_j <= {1'b0, top_lvl}) begin
      au_lvl = 2'(au_j - 3'd1);
      au_vic = 1'b1;
      au_ret = S_HOLE;
    end else begin
      au_lvl = 2'd0;
      au_vic = 1'b0;
      au_ret = S_SLOT;
    end
  end

  // Scan requests of the sequencer.
  always_comb begin
    go_scan = 1'b0;
    go_lvl  = 2'd0;
    go_vic  = 1'b1;
    go_ret  = S_IDLE;
    case (state)
      S_AGE: begin
        if (age_end) begin
          if (!found_any) begin
            go_scan = 1'b1;
            go_lvl  = 2'd3;
            go_ret  = S_MISS;
          end else if (flvl != 2'd0) begin
            go_scan = 1'b1;
            go_lvl  = flvl - 2'd1;
            go_ret  = S_DOWN;
          end
        end
      end
      S_MISS: begin
        go_scan = 1'b1;
        go_lvl  = 2'd2;
        go_ret  = S_DOWN;
      end
      S_DOWN2: begin
        go_scan = 1'b1;
        if (k != 2'd1) begin
          go_lvl = k - 2'd2;
          go_ret = S_DOWN;
        end else begin
          go_lvl = au_lvl;
          go_vic = au_vic;
          go_ret = au_ret;
        end
      end
      S_HOLE: begin
        go_scan = 1'b1;
        if (inv_hit) begin
          go_lvl = j[1:0];
          go_vic = 1'b0;
          go_ret = S_FILL;
        end else begin
          go_lvl = au_lvl;
          go_vic = au_vic;
          go_ret = au_ret;
        end
      end
      S_FILL: begin
        if (!have) begin
          go_scan = 1'b1;
          go_lvl  = au_lvl;
          go_vic  = au_vic;
          go_ret  = au_ret;
        end
      end
      S_FILL2: begin
        go_scan = 1'b1;
        go_lvl  = au_lvl;
        go_vic  = au_vic;
        go_ret  = au_ret;
      end
      default: begin
        go_scan = 1'b0;
      end
    endcase
  end

  // RAM write port.
  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = '0;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_AGE: begin
        we    = pv;
        waddr = paddr;
        wdata = rdata;
        if (rdata.age != elru_pkg::AGE_MAX) begin
          wdata.age = rdata.age + 1'b1;
        end
      end
      S_DOWN: begin
        we    = 1'b1;
        waddr = idx;
        wdata = best;
      end
      S_DOWN2: begin
        we    = 1'b1;
        waddr = best_idx;
        wdata = {1'b1, addr, {elru_pkg::AGE_W{1'b0}}};
      end
      S_FILL: begin
        we    = have;
        waddr = hole_idx;
        wdata = best;
      end
      S_FILL2: begin
        we    = 1'b1;
        waddr = best_idx;
        wdata = hold;
      end
      S_L1HIT: begin
        we    = 1'b1;
        waddr = idx;
        wdata = {1'b1, addr, {elru_pkg::AGE_W{1'b0}}};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign cost_sum = {1'b0, total_cost} + (elru_pkg::SUM_W + 1)'(elru_pkg::cost_of(hit_level));
  assign cyc_sum  = {1'b0, total_cycles} + (elru_pkg::SUM_W + 1)'(elru_pkg::cycles_of(hit_level));

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      cnt          <= '0;
      iss          <= 1'b0;
      pv           <= 1'b0;
      scan_clr     <= 1'b0;
      hit_found    <= 1'b0;
      rsp_valid    <= 1'b0;
      total_cost   <= '0;
      total_cycles <= '0;
    end else begin
      scan_clr <= 1'b0;

      // Read pipeline of the aging pass and the level scans.
      if (state == S_AGE || state == S_SCAN) begin
        pv    <= iss;
        paddr <= cnt;
        if (iss) begin
          if (cnt == slast) begin
            iss <= 1'b0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
      end else begin
        pv <= 1'b0;
      end

      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            addr      <= req.block_address;
            cnt       <= '0;
            slast     <= LAST;
            iss       <= 1'b1;
            hit_found <= 1'b0;
            state     <= S_AGE;
          end
        end
        S_AGE: begin
          if (hit_now && !hit_found) begin
            hit_found <= 1'b1;
            hit_idx   <= paddr;
          end
          if (age_end) begin
            idx <= fidx;
            k   <= flvl;
            if (found_any) begin
              hit_level <= {1'b0, flvl};
              top_lvl   <= flvl;
              if (flvl == 2'd0) begin
                state <= S_L1HIT;
              end
            end else begin
              hit_level <= elru_pkg::LVL_DISK;
              top_lvl   <= 2'd3;
            end
          end
        end
        S_SCAN: begin
          if (pv && paddr == slast) begin
            state <= ret;
          end
        end
        S_MISS: begin
          idx <= best_idx;
          k   <= 2'd3;
        end
        S_DOWN: begin
          state <= S_DOWN2;
        end
        S_DOWN2: begin
          k   <= k - 2'd1;
          idx <= best_idx;
          if (k == 2'd1) begin
            j <= 3'd2;
          end
        end
        S_HOLE: begin
          if (inv_hit) begin
            hold     <= best;
            hole_idx <= best_idx;
          end else begin
            j <= j + 3'd1;
          end
        end
        S_FILL: begin
          if (have) begin
            state <= S_FILL2;
          end else begin
            j <= j + 3'd1;
          end
        end
        S_FILL2: begin
          j <= j + 3'd1;
        end
        S_SLOT: begin
          slot  <= elru_pkg::SLOT_W'(best_idx);
          state <= S_DONE;
        end
        S_L1HIT: begin
          slot  <= elru_pkg::SLOT_W'(idx);
          state <= S_DONE;
        end
        S_DONE: begin
          // Load the output register once the previous beat has gone.
          if (!rsp_valid || rsp.ready) begin
            rsp_valid    <= 1'b1;
            out_level    <= hit_level;
            out_slot     <= slot;
            out_cost     <= elru_pkg::cost_of(hit_level);
            out_cyc      <= elru_pkg::cycles_of(hit_level);
            total_cost   <= cost_sum[elru_pkg::SUM_W] ? '1 : cost_sum[elru_pkg::SUM_W-1:0];
            total_cycles <= cyc_sum[elru_pkg::SUM_W] ? '1 : cyc_sum[elru_pkg::SUM_W-1:0];
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Start of a level scan.
      if (go_scan) begin
        state    <= S_SCAN;
        ret      <= go_ret;
        cnt      <= lvl_base(go_lvl);
        slast    <= lvl_last(go_lvl);
        iss      <= 1'b1;
        scan_clr <= 1'b1;
        scan_vic <= go_vic;
      end
    end
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.hit_level     = out_level;
  assign rsp.l1_slot       = out_slot;
  assign rsp.resident      = 1'b1;
  assign rsp.access_cost   = out_cost;
  assign rsp.access_cycles = out_cyc;
  assign rsp.total_cost    = total_cost;
  assign rsp.total_cycles  = total_cycles;

  // The clearing pass runs to its end before any request is taken.
  a_clear_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) && (cnt != LAST) |=> (state == S_CLEAR))
    else $error("clearing pass left early");

  // A scan never reads past the end of the level it walks.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    pv && (state == S_SCAN) |-> (paddr <= slast))
    else $error("scan read beyond its level");

  // A refill only moves an entry into a hole.
  a_fill_hole: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL2) |-> !hold.valid)
    else $error("refill overwrote a valid entry");

  // Lifting always starts below the first level.
  a_down_level: assert property (@(posedge clk) disable iff (rst)
    (state == S_DOWN) |-> (k != 2'd0))
    else $error("lift step at the first level");

endmodule

`default_nettype wire

// ===== tb/sv/tb_exclusive_four_level_lru_lookup.sv =====
// Testbench for the four-level exclusive LRU lookup, checked against a local predictor.
`timescale 1ns / 100ps

module tb_exclusive_four_level_lru_lookup;

  localparam int N1 = 8;
  localparam int N2 = 16;
  localparam int N3 = 32;
  localparam int N4 = 64;
  localparam int NMAX = 64;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [elru_pkg::LEVEL_W-1:0] hit_level;
    logic [elru_pkg::SLOT_W-1:0]  l1_slot;
    logic                         resident;
    logic [elru_pkg::COST_W-1:0]  access_cost;
    logic [elru_pkg::CYC_W-1:0]   access_cycles;
    logic [elru_pkg::SUM_W-1:0]   total_cost;
    logic [elru_pkg::SUM_W-1:0]   total_cycles;
  } lookup_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  elru_req_if req ();
  elru_rsp_if rsp ();

  exclusive_four_level_lru_lookup dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  always #5 clk = ~clk;

  // Predictor state: level index 0..3, entry index.
  logic                       pv [4][NMAX];
  logic [elru_pkg::TAG_W-1:0] pt [4][NMAX];
  logic [elru_pkg::AGE_W-1:0] pa [4][NMAX];
  logic [elru_pkg::SUM_W-1:0] cost_total;
  logic [elru_pkg::SUM_W-1:0] cycle_total;

  logic [elru_pkg::TAG_W-1:0] pending_addr[$];
  lookup_rsp_t                expected_rsp[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int idle_count = 0;
  int level_seen[5];
  bit stim_done = 0;
  bit req_fire = 0;

  function automatic int level_size(int k);
    case (k)
      0: return N1;
      1: return N2;
      2: return N3;
      default: return N4;
    endcase
  endfunction

  function automatic int find_victim(int k);
    int best;
    best = 0;
    for (int i = 0; i < level_size(k); i++) begin
      if (!pv[k][i]) return i;
      if (pa[k][i] > pa[k][best]) best = i;
    end
    return best;
  endfunction

  function automatic bit find_youngest(int k, output int idx);
    bit found;
    found = 0;
    idx = 0;
    for (int i = 0; i < level_size(k); i++) begin
      if (pv[k][i] && (!found || pa[k][i] < pa[k][idx])) begin
        idx = i;
        found = 1;
      end
    end
    return found;
  endfunction

  function automatic void swap_entry(int k, int i, int m, int j);
    logic                       v;
    logic [elru_pkg::TAG_W-1:0] t;
    logic [elru_pkg::AGE_W-1:0] a;
    v = pv[k][i]; t = pt[k][i]; a = pa[k][i];
    pv[k][i] = pv[m][j]; pt[k][i] = pt[m][j]; pa[k][i] = pa[m][j];
    pv[m][j] = v; pt[m][j] = t; pa[m][j] = a;
  endfunction

  // Move an entry up one level at a time, refilling holes on the way back.
  function automatic void promote(int k, int idx);
    int vic;
    int hole;
    int y;
    vic = find_victim(k - 1);
    swap_entry(k - 1, vic, k, idx);
    if (k == 1) begin
      pa[0][vic] = '0;
      return;
    end
    promote(k - 1, vic);
    hole = find_victim(k - 1);
    if (!pv[k - 1][hole] && find_youngest(k, y)) swap_entry(k - 1, hole, k, y);
  endfunction

  function automatic logic [elru_pkg::SUM_W-1:0] sat_sum(logic [elru_pkg::SUM_W-1:0] a,
                                                         logic [elru_pkg::SUM_W-1:0] b);
    logic [elru_pkg::SUM_W:0] s;
    s = a + b;
    return s[elru_pkg::SUM_W] ? {elru_pkg::SUM_W{1'b1}} : s[elru_pkg::SUM_W-1:0];
  endfunction

  function automatic lookup_rsp_t predict_lookup(logic [elru_pkg::TAG_W-1:0] addr);
    lookup_rsp_t r;
    int lvl;
    int where;
    int slot;
    int vic;
    logic [elru_pkg::COST_W-1:0] c;
    logic [elru_pkg::CYC_W-1:0] cy;
    lvl = 4;
    where = 0;
    for (int k = 0; k < 4; k++)
      for (int i = 0; i < level_size(k); i++)
        if (pa[k][i] != elru_pkg::AGE_MAX) pa[k][i] = pa[k][i] + 1;
    for (int k = 0; k < 4; k++) begin
      if (lvl != 4) break;
      for (int i = 0; i < level_size(k); i++) begin
        if (pv[k][i] && pt[k][i] == addr) begin
          lvl = k;
          where = i;
          break;
        end
      end
    end
    if (lvl == 0) begin
      pa[0][where] = '0;
    end else if (lvl < 4) begin
      promote(lvl, where);
    end else begin
      vic = find_victim(3);
      pv[3][vic] = 1'b1;
      pt[3][vic] = addr;
      promote(3, vic);
    end
    slot = where;
    if (lvl != 0) void'(find_youngest(0, slot));
    case (lvl)
      0: begin c = 17'd10; cy = 14'd1; end
      1: begin c = 17'd110; cy = 14'd10; end
      2: begin c = 17'd1110; cy = 14'd100; end
      3: begin c = 17'd11110; cy = 14'd1000; end
      default: begin c = 17'd111110; cy = 14'd10000; end
    endcase
    cost_total = sat_sum(cost_total, elru_pkg::SUM_W'(c));
    cycle_total = sat_sum(cycle_total, elru_pkg::SUM_W'(cy));
    r.hit_level = elru_pkg::LEVEL_W'(lvl);
    r.l1_slot = elru_pkg::SLOT_W'(slot);
    r.resident = 1'b1;
    r.access_cost = c;
    r.access_cycles = cy;
    r.total_cost = cost_total;
    r.total_cycles = cycle_total;
    return r;
  endfunction

  // Driver: offers pending addresses, changing inputs on the falling edge.
  initial begin
    req.valid = 1'b0;
    req.block_address = '0;
  end

  // Remembers whether the request beat was taken at the last rising edge.
  always @(posedge clk) begin
    req_fire <= req.valid && req.ready && !rst;
  end

  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (req.valid && !req_fire) begin
      // Hold the offered beat.
    end else if (pending_addr.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      req.valid <= 1'b1;
      req.block_address <= pending_addr.pop_front();
    end else begin
      req.valid <= 1'b0;
      req.block_address <= elru_pkg::TAG_W'($urandom);
    end
  end

  // Receiver readiness, with an optional long hold-off.
  initial rsp.ready = 1'b0;

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on request beats and checks response beats.
  always @(posedge clk) begin
    lookup_rsp_t got;
    lookup_rsp_t exp;
    if (!rst) begin
      if (req.valid && req.ready) begin
        expected_rsp.push_back(predict_lookup(req.block_address));
        accepted <= accepted + 1;
      end
      if (rsp.valid && rsp.ready) begin
        got.hit_level = rsp.hit_level;
        got.l1_slot = rsp.l1_slot;
        got.resident = rsp.resident;
        got.access_cost = rsp.access_cost;
        got.access_cycles = rsp.access_cycles;
        got.total_cost = rsp.total_cost;
        got.total_cycles = rsp.total_cycles;
        if (expected_rsp.size() == 0) begin
          $error("response beat with no access outstanding");
          errors = errors + 1;
        end else begin
          exp = expected_rsp.pop_front();
          if (got.hit_level < 5) level_seen[got.hit_level]++;
          if (got.hit_level !== exp.hit_level) begin
            $error("hit_level expected %0d got %0d", exp.hit_level, got.hit_level);
            errors = errors + 1;
          end
          if (got.l1_slot !== exp.l1_slot) begin
            $error("l1_slot expected %0d got %0d", exp.l1_slot, got.l1_slot);
            errors = errors + 1;
          end
          if (got.resident !== exp.resident) begin
            $error("resident expected %0d got %0d", exp.resident, got.resident);
            errors = errors + 1;
          end
          if (got.access_cost !== exp.access_cost) begin
            $error("access_cost expected %0d got %0d", exp.access_cost, got.access_cost);
            errors = errors + 1;
          end
          if (got.access_cycles !== exp.access_cycles) begin
            $error("access_cycles expected %0d got %0d", exp.access_cycles,
                   got.access_cycles);
            errors = errors + 1;
          end
          if (got.total_cost !== exp.total_cost) begin
            $error("total_cost expected %0d got %0d", exp.total_cost, got.total_cost);
            errors = errors + 1;
          end
          if (got.total_cycles !== exp.total_cycles) begin
            $error("total_cycles expected %0d got %0d", exp.total_cycles, got.total_cycles);
            errors = errors + 1;
          end
        end
        checked <= checked + 1;
      end
    end
  end

  // Watchdog: counts cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG) begin
        $display("watchdog expired with %0d responses outstanding", expected_rsp.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Random address drawn mostly from a small working set so that hits occur.
  function automatic logic [elru_pkg::TAG_W-1:0] pick_addr(int pool);
    int r;
    r = $urandom_range(99);
    if (r < 8) return elru_pkg::TAG_W'($urandom);
    if (r < 12) return ($urandom_range(1)) ? {elru_pkg::TAG_W{1'b1}} : '0;
    return elru_pkg::TAG_W'(32'h5A000 + $urandom_range(pool - 1));
  endfunction

  task automatic wait_drained();
    while (pending_addr.size() > 0 || req.valid || expected_rsp.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    for (int k = 0; k < 4; k++)
      for (int i = 0; i < NMAX; i++) begin
        pv[k][i] = 1'b0; pt[k][i] = '0; pa[k][i] = '0;
      end
    cost_total = '0;
    cycle_total = '0;
    for (int i = 0; i < 5; i++) level_seen[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: address extremes, L1 hit, then a fill that pushes blocks to
    // L2 so that later re-accesses hit at L2 and L1, then two new blocks miss.
    pending_addr.push_back('0);
    pending_addr.push_back('0);
    pending_addr.push_back({elru_pkg::TAG_W{1'b1}});
    pending_addr.push_back({elru_pkg::TAG_W{1'b1}});
    for (int i = 0; i < 12; i++) pending_addr.push_back(elru_pkg::TAG_W'(32'h10000 + i));
    pending_addr.push_back('0);
    pending_addr.push_back(elru_pkg::TAG_W'(32'h10001));
    pending_addr.push_back(elru_pkg::TAG_W'(32'h10008));
    pending_addr.push_back(20'hAAAAA);
    pending_addr.push_back(20'h55555);

    // Random phase one: sender idles lightly, receiver heavily.
    send_idle_pct = 29;
    recv_idle_pct = 69;
    for (int i = 0; i < 220; i++) pending_addr.push_back(pick_addr(40));
    wait_drained();

    // Random phase two, with a long receiver hold-off so the block stalls.
    send_idle_pct = 69;
    recv_idle_pct = 29;
    @(negedge clk);
    hold_cycles = 3000;
    for (int i = 0; i < 215; i++) pending_addr.push_back(pick_addr(130));
    wait_drained();

    // Random phase three: no idling, large working set reaches RAM and disk.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 215; i++) pending_addr.push_back(pick_addr(200));
    wait_drained();
    repeat (600) @(posedge clk);
    stim_done = 1;
  end

  // Final report.
  initial begin
    wait (stim_done);
    $display("Ran %0d accesses, %0d responses checked.", accepted, checked);
    $display("Hits by level L1/L2/L3/RAM/disk: %0d %0d %0d %0d %0d", level_seen[0],
             level_seen[1], level_seen[2], level_seen[3], level_seen[4]);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
